// File: rtl/grs_pkg.sv
// Shared constants and types for the group reverse stream block.
// Depends on nothing; every other file takes names from here by scope.
package grs_pkg;

	localparam int MAX_GROUP = 16;
	localparam int PAYLOAD_W = 32;
	localparam int CFG_W     = 5;
	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

	typedef enum logic {
		ST_ACCEPT,
		ST_DRAIN
	} grs_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic load;
	} grs_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic emit;
		logic drain_last;
		logic out_full;
	} grs_sts_t;

endpackage

// File: rtl/grs_if.sv
// Channel interfaces for the group reverse stream block: items in, results out,
// and the group size write port. Depends on grs_pkg for widths.
interface grs_in_if;
	logic                           valid;
	logic                           ready;
	logic [grs_pkg::PAYLOAD_W-1:0]  item_payload;
	logic                           stream_end;
	modport source (output valid, output item_payload, output stream_end, input ready);
	modport sink (input valid, input item_payload, input stream_end, output ready);
endinterface

interface grs_out_if;
	logic                           valid;
	logic                           ready;
	logic [grs_pkg::PAYLOAD_W-1:0]  out_payload;
	logic                           out_last;
	modport source (output valid, output out_payload, output out_last, input ready);
	modport sink (input valid, input out_payload, input out_last, output ready);
endinterface

interface grs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [grs_pkg::CFG_W-1:0]  group_size;
	modport source (output valid, output group_size, input ready);
	modport sink (input valid, input group_size, output ready);
endinterface

// File: rtl/grs_ctrl.sv
// Controller state machine for the group reverse stream block.
// Depends on grs_pkg for the state type and the command and status structs.
module grs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  grs_pkg::grs_sts_t   sts,
	output grs_pkg::grs_cmd_t   cmd
);

	grs_pkg::grs_state_t state_q;
	grs_pkg::grs_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grs_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			grs_pkg::ST_ACCEPT: begin
				if (in_valid && sts.emit) begin
					state_next = grs_pkg::ST_DRAIN;
				end
			end
			grs_pkg::ST_DRAIN: begin
				if ((!sts.out_full || out_ready) && sts.drain_last) begin
					state_next = grs_pkg::ST_ACCEPT;
				end
			end
			default: state_next = grs_pkg::ST_ACCEPT;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			grs_pkg::ST_ACCEPT: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			grs_pkg::ST_DRAIN: begin
				// A read is issued whenever the output register is free or being emptied.
				cmd.load = !sts.out_full || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/grs_datapath.sv
// Datapath of the group reverse stream block: group buffer, fill and read
// counters, group size register and output register. Depends on grs_pkg, grs_if.
module grs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	grs_in_if.sink              items,
	grs_out_if.source           results,
	grs_cfg_if.sink             cfg,
	input  grs_pkg::grs_cmd_t   cmd,
	output grs_pkg::grs_sts_t   sts
);

	logic [grs_pkg::PAYLOAD_W-1:0] store_mem [grs_pkg::MAX_GROUP];

	logic [grs_pkg::CFG_W-1:0]     group_size_q;
	logic [grs_pkg::IDX_W-1:0]     fill_q;
	logic [grs_pkg::IDX_W-1:0]     rd_idx_q;
	logic [grs_pkg::CNT_W-1:0]     remain_q;
	logic                          rev_q;
	logic                          end_q;
	logic                          out_valid_q;
	logic [grs_pkg::PAYLOAD_W-1:0] out_payload_q;
	logic                          out_last_q;

	logic [grs_pkg::CMP_W-1:0]     gs_ext;
	logic [grs_pkg::CMP_W-1:0]     size_eff;
	logic [grs_pkg::CNT_W-1:0]     n_count;
	logic                          full_group;

	assign cfg.ready = 1'b1;

	// Sizes of zero act as one; sizes above the buffer depth are clamped.
	always_comb begin
		gs_ext = grs_pkg::CMP_W'(group_size_q);
		priority if (gs_ext == '0) begin
			size_eff = grs_pkg::CMP_W'(1);
		end else if (gs_ext > grs_pkg::CMP_W'(grs_pkg::MAX_GROUP)) begin
			size_eff = grs_pkg::CMP_W'(grs_pkg::MAX_GROUP);
		end else begin
			size_eff = gs_ext;
		end
	end

	assign n_count    = grs_pkg::CNT_W'(fill_q) + grs_pkg::CNT_W'(1);
	assign full_group = grs_pkg::CMP_W'(n_count) >= size_eff;

	assign sts.emit       = full_group || items.stream_end;
	assign sts.drain_last = remain_q == grs_pkg::CNT_W'(1);
	assign sts.out_full   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grs_pkg::GROUP_SIZE_RESET;
		end else if (cfg.valid) begin
			group_size_q <= cfg.group_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			store_mem[fill_q] <= items.item_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_idx_q <= '0;
			remain_q <= '0;
			rev_q    <= 1'b0;
			end_q    <= 1'b0;
		end else if (cmd.accept) begin
			if (sts.emit) begin
				fill_q   <= '0;
				remain_q <= n_count;
				rev_q    <= full_group;
				end_q    <= items.stream_end;
				// A full group drains from the newest entry down; a partial tail from entry zero up.
				rd_idx_q <= full_group ? fill_q : '0;
			end else begin
				fill_q <= fill_q + grs_pkg::IDX_W'(1);
			end
		end else if (cmd.load) begin
			remain_q <= remain_q - grs_pkg::CNT_W'(1);
			rd_idx_q <= rev_q ? (rd_idx_q - grs_pkg::IDX_W'(1))
			                  : (rd_idx_q + grs_pkg::IDX_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_payload_q <= store_mem[rd_idx_q];
			out_last_q    <= sts.drain_last && end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_payload = out_payload_q;
	assign results.out_last    = out_last_q;

endmodule

// File: rtl/group_reverse_stream_core.sv
// Top level of the group reverse stream block: controller plus datapath.
// Depends on grs_pkg, grs_if, grs_ctrl and grs_datapath.
//
//  channel  | port    | beat carries                   | direction
//  ---------+---------+--------------------------------+----------
//  items    | items   | item_payload[31:0], stream_end | in
//  results  | results | out_payload[31:0], out_last    | out
//  config   | cfg     | group_size[4:0]                | in
//
// An item that completes no group is stored and the next item may follow. An item that closes a group
// of n items is stored and then the n items drain, one beat per cycle while the output is not stalled;
// items wait while the buffer drains.
// Reset clears the counters, the output valid and sets the group size to 2.
// A stalled result holds in the output register and pauses the drain.
module group_reverse_stream_core (
	input  logic       clk,
	input  logic       arst_n,
	grs_in_if.sink     items,
	grs_out_if.source  results,
	grs_cfg_if.sink    cfg
);

	grs_pkg::grs_cmd_t cmd;
	grs_pkg::grs_sts_t sts;

	grs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	grs_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

// File: rtl/grs_checker.sv
// Port-level checks for the group reverse stream block, bound to the top level.
// Depends on grs_pkg for widths.
module grs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           in_stream_end,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [grs_pkg::PAYLOAD_W-1:0]  out_payload,
	input logic                           out_last,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [grs_pkg::CFG_W-1:0]      cfg_group_size
);

	logic [grs_pkg::CFG_W-1:0] size_shadow_q;

	// Tracks the group size last written through the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_shadow_q <= grs_pkg::GROUP_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_shadow_q <= cfg_group_size;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_last))
		else $error("result beat changed while stalled");

	// The end of a list always produces at least one result, so the block drains.
	a_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_stream_end |=> !in_ready)
		else $error("stream end did not start a drain");

	// With a group size of one or zero every item is a complete group.
	a_pass_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (size_shadow_q <= grs_pkg::CFG_W'(1)) |=> !in_ready)
		else $error("single item group did not drain");

endmodule

bind group_reverse_stream_core grs_checker u_grs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (items.valid),
	.in_ready       (items.ready),
	.in_stream_end  (items.stream_end),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_payload    (results.out_payload),
	.out_last       (results.out_last),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_group_size (cfg.group_size)
);

// File: verif/tb_group_reverse_stream_core.sv
`timescale 1ns / 1ps
// Testbench for group_reverse_stream_core: directed and random lists checked against an
// in-bench prediction of the group reversal. Depends on grs_pkg, the grs channel interfaces
// and the RTL of the block.
module tb_group_reverse_stream_core;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int CFG_SETTLE     = 8;
	localparam int FINAL_SETTLE   = 2 * grs_pkg::MAX_GROUP + 8;
	localparam int RANDOM_ITEMS   = 500;
	localparam int RANDOM_PHASES  = 10;

	typedef struct packed {
		logic [grs_pkg::PAYLOAD_W-1:0] payload;
		logic                          is_last;
	} result_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	grs_in_if  items_ch ();
	grs_out_if results_ch ();
	grs_cfg_if cfg_ch ();

	group_reverse_stream_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always #2 clk = ~clk;

	// Beats the block still owes, oldest first.
	result_beat_t                  pending_beats[$];
	logic [grs_pkg::PAYLOAD_W-1:0] group_buf [grs_pkg::MAX_GROUP];
	int                            fill_cnt;
	logic [grs_pkg::CFG_W-1:0]     cur_size;
	int                            error_count;
	int                            items_sent;
	int                            idle_cycles;
	int                            ready_hold;
	bit                            gaps_on;

	function automatic int clamp_size(input logic [grs_pkg::CFG_W-1:0] size);
		if (size == 0)
			return 1;
		if (size > grs_pkg::MAX_GROUP)
			return grs_pkg::MAX_GROUP;
		return int'(size);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Buffers one item and queues the beats it releases: a full group comes out reversed,
	// a short group closed by the end of the list comes out in arrival order.
	function automatic void predict_reverse_groups(input logic [grs_pkg::PAYLOAD_W-1:0] payload,
			input logic list_end);
		result_beat_t beat;
		int n;
		group_buf[fill_cnt] = payload;
		fill_cnt++;
		n = fill_cnt;
		if (n >= clamp_size(cur_size)) begin
			for (int k = 0; k < n; k++) begin
				beat.payload = group_buf[n - 1 - k];
				beat.is_last = list_end && (k == n - 1);
				pending_beats.push_back(beat);
			end
			fill_cnt = 0;
		end else if (list_end) begin
			for (int k = 0; k < n; k++) begin
				beat.payload = group_buf[k];
				beat.is_last = (k == n - 1);
				pending_beats.push_back(beat);
			end
			fill_cnt = 0;
		end
	endfunction

	task automatic send_item(input logic [grs_pkg::PAYLOAD_W-1:0] payload, input logic list_end);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.item_payload <= payload;
		items_ch.stream_end   <= list_end;
		do @(posedge clk); while (!items_ch.ready);
		predict_reverse_groups(payload, list_end);
		items_sent++;
	endtask

	task automatic send_list(input int len);
		for (int i = 0; i < len; i++)
			send_item($urandom, i == len - 1);
	endtask

	// The group size may only change once the block has drained what it owes.
	task automatic write_group_size(input logic [grs_pkg::CFG_W-1:0] size);
		items_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.group_size <= size;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_size = size;
	endtask

	task automatic test_reset_size();
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b1);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'h0000_0001, 1'b1);
	endtask

	task automatic test_pass_through();
		write_group_size(grs_pkg::CFG_W'(1));
		send_item(32'h1234_5678, 1'b0);
		send_item(32'h8765_4321, 1'b1);
	endtask

	task automatic test_full_group();
		write_group_size(grs_pkg::CFG_W'(grs_pkg::MAX_GROUP));
		send_list(grs_pkg::MAX_GROUP);
	endtask

	// Three items sit in a group of six when the size drops to two, so the next
	// item flushes all four reversed.
	task automatic test_shrink_midgroup();
		write_group_size(grs_pkg::CFG_W'(6));
		send_item(32'hDEAD_0001, 1'b0);
		send_item(32'hDEAD_0002, 1'b0);
		send_item(32'hDEAD_0003, 1'b0);
		write_group_size(grs_pkg::CFG_W'(2));
		send_item(32'hDEAD_0004, 1'b1);
	endtask

	task automatic test_zero_size();
		write_group_size(grs_pkg::CFG_W'(0));
		send_item(32'h0F0F_0F0F, 1'b0);
		send_item(32'hF0F0_F0F0, 1'b1);
	endtask

	task automatic test_random_lists();
		int phase_start;
		int eff;
		int len;
		int r;
		int remaining;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_group_size(grs_pkg::CFG_W'(1));
				1: write_group_size(grs_pkg::CFG_W'(grs_pkg::MAX_GROUP));
				2: write_group_size(grs_pkg::CFG_W'(0));
				3: write_group_size(grs_pkg::CFG_W'(31));
				default: write_group_size(
					grs_pkg::CFG_W'($urandom_range(2, grs_pkg::MAX_GROUP - 1)));
			endcase
			gaps_on = (phase != 4);
			eff = clamp_size(cur_size);
			phase_start = items_sent;
			while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
				r = $urandom_range(0, 9);
				if (r < 3)
					len = $urandom_range(1, eff);
				else if (r < 5)
					len = eff * $urandom_range(1, 3);
				else
					len = $urandom_range(1, 40);
				// The last list of a phase is cut short so each phase sends its share.
				remaining = RANDOM_ITEMS / RANDOM_PHASES - (items_sent - phase_start);
				if (len > remaining)
					len = remaining;
				send_list(len);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Output stall pattern: mostly short holds, now and then a long one; with gaps off, ready stays high.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (!gaps_on) begin
			results_ch.ready <= 1'b1;
		end else if ($urandom_range(0, 99) < 75) begin
			results_ch.ready <= 1'b1;
			ready_hold = $urandom_range(0, 6);
		end else begin
			results_ch.ready <= 1'b0;
			ready_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin
		result_beat_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual payload %h last %b",
					$time, results_ch.out_payload, results_ch.out_last);
				error_count++;
			end else begin
				want = pending_beats.pop_front();
				if (results_ch.out_payload !== want.payload) begin
					$display("%0t: out_payload mismatch: expected %h, actual %h",
						$time, want.payload, results_ch.out_payload);
					error_count++;
				end
				if (results_ch.out_last !== want.is_last) begin
					$display("%0t: out_last mismatch: expected %b, actual %b",
						$time, want.is_last, results_ch.out_last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (items_ch.valid && items_ch.ready)
				|| (results_ch.valid && results_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		items_ch.valid        = 1'b0;
		items_ch.item_payload = '0;
		items_ch.stream_end   = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.group_size     = grs_pkg::GROUP_SIZE_RESET;
		results_ch.ready      = 1'b0;
		arst_n                = 1'b0;
		fill_cnt              = 0;
		cur_size              = grs_pkg::GROUP_SIZE_RESET;
		error_count           = 0;
		items_sent            = 0;
		idle_cycles           = 0;
		ready_hold            = 0;
		gaps_on               = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_size();
		test_pass_through();
		test_full_group();
		test_shrink_midgroup();
		test_zero_size();
		test_random_lists();

		items_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (FINAL_SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
